// File: design/irm_pkg.sv
package irm_pkg;
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;
endpackage

// File: design/irm_if.sv
interface irm_req_if #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic [KEY_BITS-1:0]   key_begin;
	logic [KEY_BITS-1:0]   key_end;
	logic [VALUE_BITS-1:0] new_value;

	modport source (output valid, operation, key_begin, key_end, new_value, input ready);
	modport sink   (input valid, operation, key_begin, key_end, new_value, output ready);
endinterface

interface irm_rsp_if #(
	parameter int VALUE_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] found_value;
	logic [1:0]            status;

	modport source (output valid, found_value, status, input ready);
	modport sink   (input valid, found_value, status, output ready);
endinterface

// File: design/interval_range_map.sv
// Each request is answered from the N stored boundaries (at most TABLE_DEPTH): an assign with
// an empty interval is answered without a scan, a lookup scans the table, and an assign
// scans it and then copies it. One request is in flight at a time; the next one can be taken
// in the cycle after the response is accepted. The time is set by a single table memory port
// that visits one entry at a time (address, then compare or copy).
// Reset (arst_n low) empties the table and sets initial_value to 0; the memory is not cleared.
module interval_range_map #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_BITS    = 32,
	parameter int VALUE_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [VALUE_BITS-1:0] cfg_wr_data,
	irm_req_if.sink               req,
	irm_rsp_if.source             rsp
);
	import irm_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(TABLE_DEPTH + 3);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SCAN_W, S_PLAN, S_MOVE, S_MOVE_W, S_INS, S_RESP
	} state_t;

	state_t state_q;

	// Two memories: the table and a working copy; the result is built in the
	// working copy and the roles are swapped by a bank bit on commit.
	logic [KEY_BITS-1:0]   keys0 [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] vals0 [TABLE_DEPTH];
	logic [KEY_BITS-1:0]   keys1 [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] vals1 [TABLE_DEPTH];
	logic                  bank_q;

	logic [VALUE_BITS-1:0] init_q;
	logic [CW-1:0]         count_q;

	logic                  op_q;
	logic [KEY_BITS-1:0]   kb_q, ke_q;
	logic [VALUE_BITS-1:0] nv_q;

	// Scan results.
	logic [CW-1:0]         below_q;    // entries with key < kb
	logic [CW-1:0]         upto_q;     // entries with key <= ke
	logic [CW-1:0]         lessend_q;  // entries with key < ke
	logic [VALUE_BITS-1:0] prev_q;     // value just below kb
	logic [VALUE_BITS-1:0] at_kb_q;    // value at kb
	logic [VALUE_BITS-1:0] end_q;      // value at ke

	logic [CW-1:0]         rd_idx_q;
	logic [NW-1:0]         wr_idx_q;
	logic [1:0]            ins_q;      // insertion step
	logic                  phase_q;    // 0 copy below, 1 copy above

	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;

	logic [VALUE_BITS-1:0] out_val_q;
	status_t               out_st_q;

	// Read port of the current table, write port of the working copy.
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [VALUE_BITS-1:0] wr_val;

	always_ff @(posedge clk) begin
		if (bank_q) begin
			rd_key_q <= keys1[rd_idx_q[IW-1:0]];
			rd_val_q <= vals1[rd_idx_q[IW-1:0]];
		end else begin
			rd_key_q <= keys0[rd_idx_q[IW-1:0]];
			rd_val_q <= vals0[rd_idx_q[IW-1:0]];
		end
		if (wr_en) begin
			if (bank_q) begin
				keys0[wr_addr] <= wr_key;
				vals0[wr_addr] <= wr_val;
			end else begin
				keys1[wr_addr] <= wr_key;
				vals1[wr_addr] <= wr_val;
			end
		end
	end

	// Final count of the new table.
	logic          need_kb, need_ke, have_end;
	logic [NW-1:0] new_n;
	assign need_kb  = (prev_q != nv_q);
	assign need_ke  = (end_q != nv_q);
	assign have_end = (upto_q != lessend_q);
	assign new_n = NW'(below_q) + NW'(need_kb) + NW'(need_ke)
		+ NW'(count_q) - NW'(lessend_q) - NW'(have_end);

	logic ins_now;
	assign ins_now = (state_q == S_INS);
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_idx_q[IW-1:0];
		wr_key  = rd_key_q;
		wr_val  = rd_val_q;
		if (state_q == S_MOVE_W) begin
			wr_en = 1'b1;
		end else if (ins_now) begin
			if (ins_q == 2'd0) begin
				wr_en  = need_kb;
				wr_key = kb_q;
				wr_val = nv_q;
			end else if (ins_q == 2'd1) begin
				wr_en  = need_ke;
				wr_key = ke_q;
				wr_val = end_q;
			end
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = (state_q == S_RESP);
	assign rsp.found_value = out_val_q;
	assign rsp.status      = out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bank_q    <= 1'b0;
			init_q    <= '0;
			count_q   <= '0;
			out_st_q  <= ST_DONE;
			out_val_q <= '0;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			ins_q     <= '0;
			phase_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				init_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q      <= req.operation;
						kb_q      <= req.key_begin;
						ke_q      <= req.key_end;
						nv_q      <= req.new_value;
						below_q   <= '0;
						upto_q    <= '0;
						lessend_q <= '0;
						prev_q    <= init_q;
						at_kb_q   <= init_q;
						end_q     <= init_q;
						rd_idx_q  <= '0;
						if (req.operation == OP_ASSIGN &&
						    req.key_begin >= req.key_end) begin
							out_val_q <= '0;
							out_st_q  <= ST_EMPTY;
							state_q   <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// One entry at a time: issue a read, evaluate it next cycle in S_SCAN_W.
					if (rd_idx_q == count_q) begin
						state_q <= S_PLAN;
					end else begin
						state_q <= S_SCAN_W;
					end
				end
				S_SCAN_W: begin
					if (rd_key_q < kb_q) begin
						below_q <= below_q + 1'b1;
						prev_q  <= rd_val_q;
					end
					if (rd_key_q <= kb_q) begin
						at_kb_q <= rd_val_q;
					end
					if (rd_key_q < ke_q) begin
						lessend_q <= lessend_q + 1'b1;
					end
					if (rd_key_q <= ke_q) begin
						upto_q <= upto_q + 1'b1;
						end_q  <= rd_val_q;
					end
					rd_idx_q <= rd_idx_q + 1'b1;
					state_q  <= S_SCAN;
				end
				S_PLAN: begin
					if (op_q == OP_LOOKUP) begin
						out_val_q <= at_kb_q;
						out_st_q  <= ST_DONE;
						state_q   <= S_RESP;
					end else if (new_n > NW'(TABLE_DEPTH)) begin
						out_val_q <= '0;
						out_st_q  <= ST_FULL;
						state_q   <= S_RESP;
					end else begin
						rd_idx_q <= '0;
						wr_idx_q <= '0;
						phase_q  <= 1'b0;
						state_q  <= S_MOVE;
					end
				end
				S_MOVE: begin
					if (!phase_q && rd_idx_q == below_q) begin
						ins_q   <= '0;
						state_q <= S_INS;
					end else if (phase_q && rd_idx_q == count_q) begin
						bank_q    <= ~bank_q;
						count_q   <= CW'(new_n);
						out_val_q <= '0;
						out_st_q  <= ST_DONE;
						state_q   <= S_RESP;
					end else begin
						state_q <= S_MOVE_W;
					end
				end
				S_MOVE_W: begin
					wr_idx_q <= wr_idx_q + 1'b1;
					rd_idx_q <= rd_idx_q + 1'b1;
					state_q  <= S_MOVE;
				end
				S_INS: begin
					if (ins_q == 2'd0) begin
						if (need_kb) wr_idx_q <= wr_idx_q + 1'b1;
						ins_q <= 2'd1;
					end else begin
						if (need_ke) wr_idx_q <= wr_idx_q + 1'b1;
						// Skip entries inside the interval and one at ke itself.
						rd_idx_q <= lessend_q + CW'(have_end);
						phase_q  <= 1'b1;
						state_q  <= S_MOVE;
					end
				end
				S_RESP: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond depth");
	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_st_q == ST_FULL) |-> $stable(count_q))
		else $error("rejected assign changed the table");
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request taken while response pending");
	a_lookup_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && op_q == OP_LOOKUP) |-> out_st_q == ST_DONE)
		else $error("lookup with bad status");
endmodule
